[rtl/crcd_pkg.sv]
// ----------------------------------------------------------------------------
// crcd_pkg
// Shared widths, codes, stage structs and the arrow cursor bitmap for the
// clipped rectangle and cursor drawer.
// ----------------------------------------------------------------------------
package crcd_pkg;

  localparam int DIM_W       = 14;
  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 32;
  localparam int OFFS_W      = 26;
  localparam int POS_W       = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 64;
  localparam int MAX_DIM     = 8192;
  localparam int CURSOR_ROWS = 19;
  localparam int CURSOR_COLS = 12;
  localparam int BITMAP_COLS = 16;

  typedef enum logic [1:0] {
    OP_FILL    = 2'd0,
    OP_OUTLINE = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PITCH_WORDS   = 2'd2,
    REG_CURSOR_COLOR  = 2'd3
  } reg_idx_t;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [DIM_W-1:0]   pitch_words;
    logic [COLOR_W-1:0] cursor_color;
  } cfg_t;

  // Candidate pixel handed from the walker to the pixel stage.
  typedef struct packed {
    logic                    valid;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    mask;
    logic                    done;
    logic [COLOR_W-1:0]      color;
  } cand_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if ({1'b0, v} > (DIM_W+1)'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  function automatic logic [BITMAP_COLS-1:0] arrow_row(input logic [4:0] row);
    logic [BITMAP_COLS-1:0] b;
    case (row)
      5'd0:    b = 16'h8000;
      5'd1:    b = 16'hC000;
      5'd2:    b = 16'hE000;
      5'd3:    b = 16'hF000;
      5'd4:    b = 16'hF800;
      5'd5:    b = 16'hFC00;
      5'd6:    b = 16'hFE00;
      5'd7:    b = 16'hFF00;
      5'd8:    b = 16'hFF80;
      5'd9:    b = 16'hFFC0;
      5'd10:   b = 16'hFC00;
      5'd11:   b = 16'hEC00;
      5'd12:   b = 16'hC600;
      5'd13:   b = 16'h8600;
      5'd14:   b = 16'h0300;
      5'd15:   b = 16'h0300;
      5'd16:   b = 16'h0180;
      5'd17:   b = 16'h0180;
      default: b = 16'h0000;
    endcase
    return b;
  endfunction

  // The leftmost bitmap column is the most significant bit of a row.
  function automatic logic cursor_bit(input logic [DIM_W-1:0] row,
                                      input logic [DIM_W-1:0] col);
    logic [BITMAP_COLS-1:0] b;
    logic hit;
    b   = arrow_row(row[4:0]);
    hit = 1'b0;
    if (row < DIM_W'(CURSOR_ROWS) && col < DIM_W'(BITMAP_COLS))
      hit = b[4'(BITMAP_COLS-1) - col[3:0]];
    return hit;
  endfunction

endpackage

[rtl/clipped_rect_and_cursor_drawer.sv]
// ----------------------------------------------------------------------------
// clipped_rect_and_cursor_drawer
// 2D draw engine: a command request loads fill, outline, arrow cursor or
// clear; each tick request yields one clipped pixel write.
//
//   Channel  Ports                     Content
//   in       in_tvalid/tready/tdata    draw_op, origin, size, colour
//            in_tuser                  req_type (0 command, 1 tick)
//   out      out_tvalid/tready/tdata   write_enable, pixel_offset, pixel_value
//            out_tlast                 done_res
//   cfg      cfg_we/index/wdata        screen size, pitch, cursor colour
//
// One request is taken every cycle while in_tready is high; a tick's write
// passes the candidate register, then the clip and multiply output register.
// Commands and idle ticks are consumed with no write.
// Reset is synchronous and clears the walk and both stage valids.
// A stalled output holds both stages; in_tready drops only when both are full.
// ----------------------------------------------------------------------------
module clipped_rect_and_cursor_drawer
  import crcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] draw_op, [17:2] origin_x, [33:18] origin_y, [47:34] rect_width,
  // [61:48] rect_height, [93:62] draw_color
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] write_enable, [26:1] pixel_offset, [58:27] pixel_value
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  cand_t cand;
  logic  adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= '0;
      cfg_r.screen_height <= '0;
      cfg_r.pitch_words   <= '0;
      cfg_r.cursor_color  <= '1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[DIM_W-1:0];
        REG_PITCH_WORDS:   cfg_r.pitch_words   <= cfg_wdata[DIM_W-1:0];
        REG_CURSOR_COLOR:  cfg_r.cursor_color  <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  crcd_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_req_type    (in_tuser),
    .in_draw_op     (in_tdata[1:0]),
    .in_origin_x    (in_tdata[17:2]),
    .in_origin_y    (in_tdata[33:18]),
    .in_rect_width  (in_tdata[47:34]),
    .in_rect_height (in_tdata[61:48]),
    .in_draw_color  (in_tdata[93:62]),
    .adv            (adv),
    .cand           (cand)
  );

  crcd_pixel u_pixel (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cand      (cand),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

[rtl/crcd_walker.sv]
// ----------------------------------------------------------------------------
// crcd_walker
// Holds the active command and steps its pixel walk, one candidate for each
// tick request, into a registered candidate stage.
// ----------------------------------------------------------------------------
module crcd_walker
  import crcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [1:0]         in_draw_op,
  input  logic [COORD_W-1:0] in_origin_x,
  input  logic [COORD_W-1:0] in_origin_y,
  input  logic [DIM_W-1:0]   in_rect_width,
  input  logic [DIM_W-1:0]   in_rect_height,
  input  logic [COLOR_W-1:0] in_draw_color,
  input  logic               adv,
  output cand_t              cand
);

  logic               busy_r, busy_nxt;
  op_t                op_r, op_nxt;
  logic [COORD_W-1:0] base_x_r, base_x_nxt;
  logic [COORD_W-1:0] base_y_r, base_y_nxt;
  logic [DIM_W-1:0]   span_w_r, span_w_nxt;
  logic [DIM_W-1:0]   span_h_r, span_h_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt;
  logic [1:0]         phase_r, phase_nxt;
  cand_t              cand_r, cand_nxt;

  logic                    accept, tick_go;
  logic [DIM_W:0]          col_inc, row_inc;
  logic                    col_wrap, row_wrap;
  logic signed [POS_W-1:0] bx, by, col_s, row_s, w_m1, h_m1;
  logic signed [POS_W-1:0] cx, cy;
  logic                    cmask, cdone;
  logic [DIM_W-1:0]        new_w, new_h;

  assign in_ready = !cand_r.valid || adv;
  assign accept   = in_valid && in_ready;
  assign tick_go  = accept && (in_req_type == REQ_TICK) && busy_r;
  assign cand     = cand_r;

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_wrap = col_inc >= {1'b0, span_w_r};
  assign row_wrap = row_inc >= {1'b0, span_h_r};
  assign bx       = {{(POS_W-COORD_W){base_x_r[COORD_W-1]}}, base_x_r};
  assign by       = {{(POS_W-COORD_W){base_y_r[COORD_W-1]}}, base_y_r};
  assign col_s    = {{(POS_W-DIM_W){1'b0}}, col_r};
  assign row_s    = {{(POS_W-DIM_W){1'b0}}, row_r};
  assign w_m1     = {{(POS_W-DIM_W){1'b0}}, span_w_r} - POS_W'(1);
  assign h_m1     = {{(POS_W-DIM_W){1'b0}}, span_h_r} - POS_W'(1);
  assign new_w    = sat_dim(in_rect_width);
  assign new_h    = sat_dim(in_rect_height);

  always_comb begin
    busy_nxt   = busy_r;
    op_nxt     = op_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    span_w_nxt = span_w_r;
    span_h_nxt = span_h_r;
    color_nxt  = color_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    phase_nxt  = phase_r;
    cx         = bx + col_s;
    cy         = by + row_s;
    cmask      = 1'b1;
    cdone      = 1'b0;

    if (op_r == OP_OUTLINE) begin
      if (!phase_r[1]) begin
        cx = bx + col_s;
        cy = phase_r[0] ? by + h_m1 : by;
        if (!phase_r[0]) begin
          phase_nxt = 2'd1;
        end else begin
          phase_nxt = 2'd0;
          col_nxt   = col_inc[DIM_W-1:0];
          if (col_wrap) begin
            phase_nxt = 2'd2;
            row_nxt   = '0;
            if (span_h_r == '0) cdone = 1'b1;
          end
        end
      end else begin
        cx = phase_r[0] ? bx + w_m1 : bx;
        cy = by + row_s;
        if (!phase_r[0]) begin
          phase_nxt = 2'd3;
        end else begin
          phase_nxt = 2'd2;
          row_nxt   = row_inc[DIM_W-1:0];
          if (row_wrap) cdone = 1'b1;
        end
      end
    end else begin
      if (op_r == OP_CURSOR) cmask = cursor_bit(row_r, col_r);
      col_nxt = col_inc[DIM_W-1:0];
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_W-1:0];
        if (row_wrap) cdone = 1'b1;
      end
    end

    if (!tick_go) begin
      col_nxt   = col_r;
      row_nxt   = row_r;
      phase_nxt = phase_r;
    end else if (cdone) begin
      busy_nxt  = 1'b0;
      col_nxt   = '0;
      row_nxt   = '0;
      phase_nxt = 2'd0;
    end

    // A command is taken only while idle; one that arrives while busy is dropped.
    if (accept && (in_req_type == REQ_COMMAND) && !busy_r) begin
      op_nxt     = op_t'(in_draw_op);
      base_x_nxt = in_origin_x;
      base_y_nxt = in_origin_y;
      span_w_nxt = new_w;
      span_h_nxt = new_h;
      color_nxt  = in_draw_color;
      col_nxt    = '0;
      row_nxt    = '0;
      phase_nxt  = 2'd0;
      case (op_t'(in_draw_op))
        OP_CURSOR: begin
          span_w_nxt = DIM_W'(CURSOR_COLS);
          span_h_nxt = DIM_W'(CURSOR_ROWS);
          color_nxt  = cfg.cursor_color;
          busy_nxt   = 1'b1;
        end
        OP_CLEAR: begin
          base_x_nxt = '0;
          base_y_nxt = '0;
          span_w_nxt = cfg.screen_width;
          span_h_nxt = cfg.screen_height;
          busy_nxt   = (cfg.screen_width != '0) && (cfg.screen_height != '0);
        end
        OP_FILL: begin
          busy_nxt = (new_w != '0) && (new_h != '0);
        end
        default: begin
          busy_nxt = (new_w != '0) || (new_h != '0);
          if (new_w == '0) phase_nxt = 2'd2;
        end
      endcase
    end

    cand_nxt = cand_r;
    if (tick_go) begin
      cand_nxt.valid = 1'b1;
      cand_nxt.x     = cx;
      cand_nxt.y     = cy;
      cand_nxt.mask  = cmask;
      cand_nxt.done  = cdone;
      cand_nxt.color = color_r;
    end else if (adv) begin
      cand_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      op_r         <= OP_FILL;
      col_r        <= '0;
      row_r        <= '0;
      phase_r      <= 2'd0;
      cand_r.valid <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      op_r         <= op_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      phase_r      <= phase_nxt;
      cand_r       <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_x_r     <= base_x_nxt;
    base_y_r     <= base_y_nxt;
    span_w_r     <= span_w_nxt;
    span_h_r     <= span_h_nxt;
    color_r      <= color_nxt;
  end

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && cdone |=> !busy_r)
    else $error("walker still busy after the last candidate");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (col_r == '0) && (row_r == '0))
    else $error("walk counters not cleared while idle");

  a_cand_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cand_r.valid && !adv |=> cand_r.valid && $stable(cand_r.x) && $stable(cand_r.y))
    else $error("stalled candidate changed");

endmodule

[rtl/crcd_pixel.sv]
// ----------------------------------------------------------------------------
// crcd_pixel
// Clips a candidate against the screen, forms the word offset y*pitch+x and
// holds the write in the output register.
// ----------------------------------------------------------------------------
module crcd_pixel
  import crcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  cand_t                 cand,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  logic                       valid_r;
  logic                       we_r, we_nxt;
  logic [OFFS_W-1:0]          offs_r, offs_nxt;
  logic [COLOR_W-1:0]         value_r, value_nxt;
  logic                       last_r;
  logic                       x_in, y_in;
  logic [2*DIM_W-1:0]         row_base;
  logic [2*DIM_W:0]           addr;

  assign adv = !valid_r || out_ready;

  // Negative coordinates fail on the sign bit before the unsigned compare.
  assign x_in = !cand.x[POS_W-1] &&
                (cand.x[POS_W-2:0] < (POS_W-1)'(cfg.screen_width));
  assign y_in = !cand.y[POS_W-1] &&
                (cand.y[POS_W-2:0] < (POS_W-1)'(cfg.screen_height));

  assign row_base = cand.y[DIM_W-1:0] * cfg.pitch_words;
  assign addr     = {1'b0, row_base} + (2*DIM_W+1)'(cand.x[DIM_W-1:0]);

  always_comb begin
    we_nxt    = cand.mask && x_in && y_in;
    offs_nxt  = we_nxt ? addr[OFFS_W-1:0] : '0;
    value_nxt = we_nxt ? cand.color : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      we_r    <= we_nxt;
      offs_r  <= offs_nxt;
      value_r <= value_nxt;
      last_r  <= cand.done;
    end
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;
  assign out_data  = {(OUT_DATA_W-1-OFFS_W-COLOR_W)'(0), value_r, offs_r, we_r};

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !we_r |-> (offs_r == '0) && (value_r == '0))
    else $error("disabled write carries a nonzero offset or value");

  a_takes_cand: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cand.valid |=> valid_r)
    else $error("candidate lost at the output register");

  a_drains: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !cand.valid |=> !valid_r)
    else $error("delivered write shown again");

endmodule
